// ----- rtl/core/ricd_pkg.sv -----
// Package for the RISC-V instruction class decoder.
// Holds the configuration type, register indexes, opcode codes and class numbers.
// It has no dependencies; every other file in rtl/core refers to it by scoped name.
package ricd_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_XLEN_MODE  = 2'd0;
  localparam logic [1:0] REG_COMPRESSED = 2'd1;
  localparam logic [1:0] REG_VECTOR     = 2'd2;
  localparam logic [1:0] REG_ATOMICS    = 2'd3;

  // Register width codes
  localparam logic [1:0] XLEN_32  = 2'd0;
  localparam logic [1:0] XLEN_64  = 2'd1;

  // Configuration as seen by the decoder
  typedef struct packed {
    logic [1:0] xlen_mode;
    logic       compressed_enable;
    logic       vector_enable;
    logic       atomics_enable;
  } cfg_t;

  typedef logic [6:0] class_t;

  // Compressed quadrants
  localparam logic [1:0] CQ_0    = 2'b00;
  localparam logic [1:0] CQ_1    = 2'b01;
  localparam logic [1:0] CQ_2    = 2'b10;
  localparam logic [1:0] CQ_FULL = 2'b11;

  // Major opcodes of 32-bit encodings
  localparam logic [6:0] OP_LOAD     = 7'h03;
  localparam logic [6:0] OP_STORE    = 7'h23;
  localparam logic [6:0] OP_BRANCH   = 7'h63;
  localparam logic [6:0] OP_LUI      = 7'h37;
  localparam logic [6:0] OP_AUIPC    = 7'h17;
  localparam logic [6:0] OP_JAL      = 7'h6F;
  localparam logic [6:0] OP_JALR     = 7'h67;
  localparam logic [6:0] OP_IMM      = 7'h13;
  localparam logic [6:0] OP_REG      = 7'h33;
  localparam logic [6:0] OP_REG_32   = 7'h3B;
  localparam logic [6:0] OP_IMM_32   = 7'h1B;
  localparam logic [6:0] OP_SYSTEM   = 7'h73;
  localparam logic [6:0] OP_FENCE    = 7'h0F;
  localparam logic [6:0] OP_LOAD_FP  = 7'h07;
  localparam logic [6:0] OP_STORE_FP = 7'h27;
  localparam logic [6:0] OP_MADD     = 7'h43;
  localparam logic [6:0] OP_MSUB     = 7'h47;
  localparam logic [6:0] OP_NMSUB    = 7'h4B;
  localparam logic [6:0] OP_NMADD    = 7'h4F;
  localparam logic [6:0] OP_FP       = 7'h53;
  localparam logic [6:0] OP_VECTOR   = 7'h57;
  localparam logic [6:0] OP_AMO      = 7'h2F;

  // funct7 groups of the register-register opcode
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_SHADD = 7'h10;
  localparam logic [6:0] F7_ALT = 7'h20;

  // Handler classes
  localparam class_t CL_C_ADDI = 7'd0;
  localparam class_t CL_C_FUNC = 7'd1;
  localparam class_t CL_C_LI   = 7'd2;
  localparam class_t CL_C_JUMP = 7'd3;
  localparam class_t CL_C_MV   = 7'd4;
  localparam class_t CL_NOP    = 7'd5;
  localparam class_t CL_LDB    = 7'd6;
  localparam class_t CL_LDH    = 7'd7;
  localparam class_t CL_LDW    = 7'd8;
  localparam class_t CL_LDD    = 7'd9;
  localparam class_t CL_INVALID = 7'd10;
  localparam class_t CL_LDBU   = 7'd11;
  localparam class_t CL_LDHU   = 7'd12;
  localparam class_t CL_LDWU   = 7'd13;
  localparam class_t CL_STB    = 7'd14;
  localparam class_t CL_STH    = 7'd15;
  localparam class_t CL_STW    = 7'd16;
  localparam class_t CL_STD    = 7'd17;
  localparam class_t CL_BEQ    = 7'd18;
  localparam class_t CL_BNE    = 7'd19;
  localparam class_t CL_BLT    = 7'd20;
  localparam class_t CL_BGE    = 7'd21;
  localparam class_t CL_BLTU   = 7'd22;
  localparam class_t CL_BGEU   = 7'd23;
  localparam class_t CL_LUI    = 7'd24;
  localparam class_t CL_AUIPC  = 7'd25;
  localparam class_t CL_JAL    = 7'd26;
  localparam class_t CL_JALR   = 7'd27;
  localparam class_t CL_LI     = 7'd28;
  localparam class_t CL_ADDI   = 7'd29;
  localparam class_t CL_SLLI   = 7'd30;
  localparam class_t CL_SLTI   = 7'd31;
  localparam class_t CL_SLTIU  = 7'd32;
  localparam class_t CL_XORI   = 7'd33;
  localparam class_t CL_SRAI   = 7'd34;
  localparam class_t CL_SRLI   = 7'd35;
  localparam class_t CL_ORI    = 7'd36;
  localparam class_t CL_ANDI   = 7'd37;
  localparam class_t CL_ADD    = 7'd38;
  localparam class_t CL_SUB    = 7'd39;
  localparam class_t CL_SLL    = 7'd40;
  localparam class_t CL_SLT    = 7'd41;
  localparam class_t CL_SLTU   = 7'd42;
  localparam class_t CL_XOR    = 7'd43;
  localparam class_t CL_SRL    = 7'd44;
  localparam class_t CL_OR     = 7'd45;
  localparam class_t CL_AND    = 7'd46;
  localparam class_t CL_MUL    = 7'd47;
  localparam class_t CL_MULH   = 7'd48;
  localparam class_t CL_MULHSU = 7'd49;
  localparam class_t CL_MULHU  = 7'd50;
  localparam class_t CL_DIV    = 7'd51;
  localparam class_t CL_DIVU   = 7'd52;
  localparam class_t CL_REM    = 7'd53;
  localparam class_t CL_REMU   = 7'd54;
  localparam class_t CL_SH1ADD = 7'd55;
  localparam class_t CL_SH2ADD = 7'd56;
  localparam class_t CL_SH3ADD = 7'd57;
  localparam class_t CL_SRA    = 7'd58;
  localparam class_t CL_FUNC   = 7'd59;
  localparam class_t CL_SYSCALL = 7'd60;
  localparam class_t CL_SYSTEM = 7'd61;
  localparam class_t CL_FLW    = 7'd62;
  localparam class_t CL_FLD    = 7'd63;
  localparam class_t CL_VLE32  = 7'd64;
  localparam class_t CL_FSW    = 7'd65;
  localparam class_t CL_FSD    = 7'd66;
  localparam class_t CL_VSE32  = 7'd67;
  localparam class_t CL_FMADD  = 7'd68;
  localparam class_t CL_FADD   = 7'd69;
  localparam class_t CL_FSUB   = 7'd70;
  localparam class_t CL_FMUL   = 7'd71;
  localparam class_t CL_FDIV   = 7'd72;
  localparam class_t CL_LAST   = CL_FDIV;

endpackage

// ----- rtl/core/ricd_cfg_regs.sv -----
// Configuration registers of the instruction class decoder.
// Depends on ricd_pkg for the register indexes and the cfg_t type.
module ricd_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [1:0]        cfg_data,
  output ricd_pkg::cfg_t    cfg
);

  ricd_pkg::cfg_t cfg_reg;

  // Each write updates the one register named by the index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.xlen_mode         <= ricd_pkg::XLEN_32;
      cfg_reg.compressed_enable <= 1'b1;
      cfg_reg.vector_enable     <= 1'b0;
      cfg_reg.atomics_enable    <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        ricd_pkg::REG_XLEN_MODE:  cfg_reg.xlen_mode         <= cfg_data;
        ricd_pkg::REG_COMPRESSED: cfg_reg.compressed_enable <= cfg_data[0];
        ricd_pkg::REG_VECTOR:     cfg_reg.vector_enable     <= cfg_data[0];
        ricd_pkg::REG_ATOMICS:    cfg_reg.atomics_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule

// ----- rtl/core/ricd_decode.sv -----
// Combinational class lookup for one instruction word.
// Depends on ricd_pkg for opcodes, class numbers and the cfg_t type.
module ricd_decode (
  input  ricd_pkg::cfg_t   cfg,
  input  logic [31:0]      word,
  output ricd_pkg::class_t cls
);

  logic [1:0]  quad;
  logic [2:0]  cf3;
  logic [4:0]  crd;
  logic [4:0]  crs2;
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [6:0]  f7;
  logic        wide;
  ricd_pkg::class_t c_cls;
  ricd_pkg::class_t f_cls;
  ricd_pkg::class_t reg_cls;

  assign quad = word[1:0];
  assign cf3  = word[15:13];
  assign crd  = word[11:7];
  assign crs2 = word[6:2];
  assign op   = word[6:0];
  assign rd   = word[11:7];
  assign f3   = word[14:12];
  assign rs1  = word[19:15];
  assign f7   = word[31:25];
  assign wide = (cfg.xlen_mode != ricd_pkg::XLEN_32);

  // Compressed encodings: quadrant and funct3 pick the class.
  always_comb begin
    c_cls = ricd_pkg::CL_C_FUNC;
    case (quad)
      ricd_pkg::CQ_1: begin
        case (cf3)
          3'd0: c_cls = (crd != 5'd0) ? ricd_pkg::CL_C_ADDI : ricd_pkg::CL_C_FUNC;
          3'd1: c_cls = (cfg.xlen_mode == ricd_pkg::XLEN_64) ? ricd_pkg::CL_C_FUNC
                                                             : ricd_pkg::CL_C_JUMP;
          3'd2: c_cls = (crd != 5'd0) ? ricd_pkg::CL_C_LI : ricd_pkg::CL_C_FUNC;
          3'd5, 3'd6, 3'd7: c_cls = ricd_pkg::CL_C_JUMP;
          default: c_cls = ricd_pkg::CL_C_FUNC;
        endcase
      end
      ricd_pkg::CQ_2: begin
        if (cf3 == 3'd4) begin
          if (crd != 5'd0 && crs2 == 5'd0) begin
            c_cls = ricd_pkg::CL_C_JUMP;
          end else if (!word[12] && crd != 5'd0) begin
            c_cls = ricd_pkg::CL_C_MV;
          end
        end
      end
      default: c_cls = ricd_pkg::CL_C_FUNC;
    endcase
  end

  // Register-register opcode: funct7 group, then funct3.
  always_comb begin
    reg_cls = ricd_pkg::CL_INVALID;
    case (f7)
      ricd_pkg::F7_BASE: begin
        case (f3)
          3'd0: reg_cls = ricd_pkg::CL_ADD;
          3'd1: reg_cls = ricd_pkg::CL_SLL;
          3'd2: reg_cls = ricd_pkg::CL_SLT;
          3'd3: reg_cls = ricd_pkg::CL_SLTU;
          3'd4: reg_cls = ricd_pkg::CL_XOR;
          3'd5: reg_cls = ricd_pkg::CL_SRL;
          3'd6: reg_cls = ricd_pkg::CL_OR;
          default: reg_cls = ricd_pkg::CL_AND;
        endcase
      end
      ricd_pkg::F7_MULDIV: reg_cls = ricd_pkg::CL_MUL + {4'd0, f3};
      ricd_pkg::F7_SHADD: begin
        case (f3)
          3'd2: reg_cls = ricd_pkg::CL_SH1ADD;
          3'd4: reg_cls = ricd_pkg::CL_SH2ADD;
          3'd6: reg_cls = ricd_pkg::CL_SH3ADD;
          default: reg_cls = ricd_pkg::CL_INVALID;
        endcase
      end
      ricd_pkg::F7_ALT: begin
        case (f3)
          3'd0: reg_cls = ricd_pkg::CL_SUB;
          3'd5: reg_cls = ricd_pkg::CL_SRA;
          default: reg_cls = ricd_pkg::CL_INVALID;
        endcase
      end
      default: reg_cls = ricd_pkg::CL_INVALID;
    endcase
  end

  // Full-width encodings: major opcode first, then the minor fields.
  always_comb begin
    f_cls = ricd_pkg::CL_INVALID;
    case (op)
      ricd_pkg::OP_LOAD: begin
        case (f3)
          3'd0: f_cls = ricd_pkg::CL_LDB;
          3'd1: f_cls = ricd_pkg::CL_LDH;
          3'd2: f_cls = ricd_pkg::CL_LDW;
          3'd3: f_cls = wide ? ricd_pkg::CL_LDD : ricd_pkg::CL_INVALID;
          3'd4: f_cls = ricd_pkg::CL_LDBU;
          3'd5: f_cls = ricd_pkg::CL_LDHU;
          3'd6: f_cls = ricd_pkg::CL_LDWU;
          default: f_cls = ricd_pkg::CL_INVALID;
        endcase
        if (rd == 5'd0) begin
          f_cls = ricd_pkg::CL_NOP;
        end
      end
      ricd_pkg::OP_STORE: begin
        case (f3)
          3'd0: f_cls = ricd_pkg::CL_STB;
          3'd1: f_cls = ricd_pkg::CL_STH;
          3'd2: f_cls = ricd_pkg::CL_STW;
          3'd3: f_cls = wide ? ricd_pkg::CL_STD : ricd_pkg::CL_INVALID;
          default: f_cls = ricd_pkg::CL_INVALID;
        endcase
      end
      ricd_pkg::OP_BRANCH: begin
        case (f3)
          3'd0: f_cls = ricd_pkg::CL_BEQ;
          3'd1: f_cls = ricd_pkg::CL_BNE;
          3'd4: f_cls = ricd_pkg::CL_BLT;
          3'd5: f_cls = ricd_pkg::CL_BGE;
          3'd6: f_cls = ricd_pkg::CL_BLTU;
          3'd7: f_cls = ricd_pkg::CL_BGEU;
          default: f_cls = ricd_pkg::CL_INVALID;
        endcase
      end
      ricd_pkg::OP_LUI:   f_cls = (rd == 5'd0) ? ricd_pkg::CL_NOP : ricd_pkg::CL_LUI;
      ricd_pkg::OP_AUIPC: f_cls = (rd == 5'd0) ? ricd_pkg::CL_NOP : ricd_pkg::CL_AUIPC;
      ricd_pkg::OP_JAL:   f_cls = ricd_pkg::CL_JAL;
      ricd_pkg::OP_JALR:  f_cls = ricd_pkg::CL_JALR;
      ricd_pkg::OP_IMM: begin
        case (f3)
          3'd0: f_cls = (rs1 == 5'd0) ? ricd_pkg::CL_LI : ricd_pkg::CL_ADDI;
          3'd1: f_cls = ricd_pkg::CL_SLLI;
          3'd2: f_cls = ricd_pkg::CL_SLTI;
          3'd3: f_cls = ricd_pkg::CL_SLTIU;
          3'd4: f_cls = ricd_pkg::CL_XORI;
          3'd5: f_cls = word[30] ? ricd_pkg::CL_SRAI : ricd_pkg::CL_SRLI;
          3'd6: f_cls = ricd_pkg::CL_ORI;
          default: f_cls = ricd_pkg::CL_ANDI;
        endcase
        if (rd == 5'd0) begin
          f_cls = ricd_pkg::CL_NOP;
        end
      end
      ricd_pkg::OP_REG: f_cls = (rd == 5'd0) ? ricd_pkg::CL_NOP : reg_cls;
      ricd_pkg::OP_REG_32, ricd_pkg::OP_IMM_32: f_cls = ricd_pkg::CL_FUNC;
      ricd_pkg::OP_SYSTEM: begin
        f_cls = (f3 == 3'd0 && word[31:20] == 12'd0) ? ricd_pkg::CL_SYSCALL
                                                      : ricd_pkg::CL_SYSTEM;
      end
      ricd_pkg::OP_FENCE: f_cls = ricd_pkg::CL_NOP;
      ricd_pkg::OP_LOAD_FP: begin
        if (f3 == 3'd2) begin
          f_cls = ricd_pkg::CL_FLW;
        end else if (f3 == 3'd3) begin
          f_cls = ricd_pkg::CL_FLD;
        end else if (f3 == 3'd6 && cfg.vector_enable) begin
          f_cls = ricd_pkg::CL_VLE32;
        end
      end
      ricd_pkg::OP_STORE_FP: begin
        if (f3 == 3'd2) begin
          f_cls = ricd_pkg::CL_FSW;
        end else if (f3 == 3'd3) begin
          f_cls = ricd_pkg::CL_FSD;
        end else if (f3 == 3'd6 && cfg.vector_enable) begin
          f_cls = ricd_pkg::CL_VSE32;
        end
      end
      ricd_pkg::OP_MADD: f_cls = ricd_pkg::CL_FMADD;
      ricd_pkg::OP_MSUB, ricd_pkg::OP_NMSUB, ricd_pkg::OP_NMADD: f_cls = ricd_pkg::CL_FUNC;
      ricd_pkg::OP_FP: begin
        case (word[31:27])
          5'd0: f_cls = ricd_pkg::CL_FADD;
          5'd1: f_cls = ricd_pkg::CL_FSUB;
          5'd2: f_cls = ricd_pkg::CL_FMUL;
          5'd3: f_cls = ricd_pkg::CL_FDIV;
          default: f_cls = ricd_pkg::CL_FUNC;
        endcase
      end
      ricd_pkg::OP_VECTOR: f_cls = cfg.vector_enable ? ricd_pkg::CL_FUNC
                                                     : ricd_pkg::CL_INVALID;
      ricd_pkg::OP_AMO: f_cls = cfg.atomics_enable ? ricd_pkg::CL_FUNC
                                                   : ricd_pkg::CL_INVALID;
      default: f_cls = ricd_pkg::CL_INVALID;
    endcase
  end

  // A word whose low bits are not both set is compressed when that decode is on.
  assign cls = (cfg.compressed_enable && quad != ricd_pkg::CQ_FULL) ? c_cls : f_cls;

endmodule

// ----- rtl/core/riscv_instruction_class_decoder.sv -----
// RISC-V instruction class decoder, top level: input register, class lookup, result register.
// The lookup is a single pass of logic between the input register and the result register.
// Throughput: one instruction per cycle while out_ready does not hold back the result stage.
// Reset: rst is synchronous and active high; it empties both stages and restores the
// configuration to 32-bit width, compressed and atomic decode on, vector decode off.
// Depends on ricd_pkg, ricd_cfg_regs and ricd_decode.
module riscv_instruction_class_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  handler_class
);

  ricd_pkg::cfg_t   cfg;
  ricd_pkg::class_t cls;
  logic             word_valid;
  logic [31:0]      word;
  logic             result_valid;
  ricd_pkg::class_t result;
  logic             result_free;
  logic             word_move;

  ricd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ricd_decode u_decode (
    .cfg  (cfg),
    .word (word),
    .cls  (cls)
  );

  // Handshake: each stage advances when the one after it is free or draining.
  assign result_free = !result_valid || out_ready;
  assign word_move   = word_valid && result_free;
  assign in_ready    = !word_valid || result_free;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= instr_word;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_free) begin
      result_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_move) begin
      result <= cls;
    end
  end

  assign out_valid     = result_valid;
  assign handler_class = result;

`ifndef SYNTHESIS
  // A decoded word always reaches the result register in the next cycle.
  assert property (@(posedge clk) disable iff (rst) word_move |=> result_valid)
    else $error("decoded word did not reach the result stage");

  // The class offered is always one of the defined handler classes.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result <= ricd_pkg::CL_LAST))
    else $error("handler class out of range");

  // With compressed decode off, a word without both low bits set is invalid.
  assert property (@(posedge clk) disable iff (rst)
    (word_move && !cfg.compressed_enable && word[1:0] != ricd_pkg::CQ_FULL)
    |=> (result == ricd_pkg::CL_INVALID))
    else $error("non-32-bit word not classed invalid");

  // Input is refused only while a word waits behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (word_valid && result_valid && !out_ready))
    else $error("input refused without a stall");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the RISC-V instruction class decoder.
// Instruction words are driven through the valid/ready input and every handler class is checked
// against an in-bench decoder across several register settings. Depends on ricd_pkg and the RTL.
module testbench;

  // Register width codes that the package does not name.
  localparam logic [1:0] XLEN_128      = 2'd2;
  localparam logic [1:0] XLEN_RESERVED = 2'd3;

  // funct3 values of the compressed quadrants that decode to something specific.
  localparam logic [2:0] CF3_ADDI  = 3'd0;
  localparam logic [2:0] CF3_JAL   = 3'd1;
  localparam logic [2:0] CF3_LI    = 3'd2;
  localparam logic [2:0] CF3_JRMV  = 3'd4;
  localparam logic [2:0] CF3_J     = 3'd5;
  localparam logic [2:0] CF3_BEQZ  = 3'd6;
  localparam logic [2:0] CF3_BNEZ  = 3'd7;

  // funct3 values of the full-length encodings that need special handling.
  localparam logic [2:0] F3_ADD_SUB = 3'd0;
  localparam logic [2:0] F3_PRIV    = 3'd0;
  localparam logic [2:0] F3_SH1     = 3'd2;
  localparam logic [2:0] F3_WORD    = 3'd2;
  localparam logic [2:0] F3_DOUBLE  = 3'd3;
  localparam logic [2:0] F3_SH2     = 3'd4;
  localparam logic [2:0] F3_SR      = 3'd5;
  localparam logic [2:0] F3_SH3     = 3'd6;
  localparam logic [2:0] F3_VEC     = 3'd6;

  // Class lookup by funct3 (FP_MAP by word bits 28:27); entry 0 sits in the lowest seven bits.
  localparam logic [55:0] LOAD_MAP = {
    ricd_pkg::CL_INVALID, ricd_pkg::CL_LDWU, ricd_pkg::CL_LDHU, ricd_pkg::CL_LDBU,
    ricd_pkg::CL_LDD, ricd_pkg::CL_LDW, ricd_pkg::CL_LDH, ricd_pkg::CL_LDB};
  localparam logic [55:0] STORE_MAP = {
    ricd_pkg::CL_INVALID, ricd_pkg::CL_INVALID, ricd_pkg::CL_INVALID, ricd_pkg::CL_INVALID,
    ricd_pkg::CL_STD, ricd_pkg::CL_STW, ricd_pkg::CL_STH, ricd_pkg::CL_STB};
  localparam logic [55:0] BRANCH_MAP = {
    ricd_pkg::CL_BGEU, ricd_pkg::CL_BLTU, ricd_pkg::CL_BGE, ricd_pkg::CL_BLT,
    ricd_pkg::CL_INVALID, ricd_pkg::CL_INVALID, ricd_pkg::CL_BNE, ricd_pkg::CL_BEQ};
  localparam logic [55:0] IMM_MAP = {
    ricd_pkg::CL_ANDI, ricd_pkg::CL_ORI, ricd_pkg::CL_SRLI, ricd_pkg::CL_XORI,
    ricd_pkg::CL_SLTIU, ricd_pkg::CL_SLTI, ricd_pkg::CL_SLLI, ricd_pkg::CL_ADDI};
  localparam logic [55:0] BASE_MAP = {
    ricd_pkg::CL_AND, ricd_pkg::CL_OR, ricd_pkg::CL_SRL, ricd_pkg::CL_XOR,
    ricd_pkg::CL_SLTU, ricd_pkg::CL_SLT, ricd_pkg::CL_SLL, ricd_pkg::CL_ADD};
  localparam logic [55:0] MULDIV_MAP = {
    ricd_pkg::CL_REMU, ricd_pkg::CL_REM, ricd_pkg::CL_DIVU, ricd_pkg::CL_DIV,
    ricd_pkg::CL_MULHU, ricd_pkg::CL_MULHSU, ricd_pkg::CL_MULH, ricd_pkg::CL_MUL};
  localparam logic [55:0] FP_MAP = {
    ricd_pkg::CL_FUNC, ricd_pkg::CL_FUNC, ricd_pkg::CL_FUNC, ricd_pkg::CL_FUNC,
    ricd_pkg::CL_FDIV, ricd_pkg::CL_FMUL, ricd_pkg::CL_FSUB, ricd_pkg::CL_FADD};

  // Every major opcode the block knows, for well-formed random instructions.
  localparam int NUM_OPCODES = 22;
  localparam logic [NUM_OPCODES*7-1:0] OPCODES = {
    ricd_pkg::OP_LOAD, ricd_pkg::OP_STORE, ricd_pkg::OP_BRANCH, ricd_pkg::OP_LUI,
    ricd_pkg::OP_AUIPC, ricd_pkg::OP_JAL, ricd_pkg::OP_JALR, ricd_pkg::OP_IMM,
    ricd_pkg::OP_REG, ricd_pkg::OP_REG_32, ricd_pkg::OP_IMM_32, ricd_pkg::OP_SYSTEM,
    ricd_pkg::OP_FENCE, ricd_pkg::OP_LOAD_FP, ricd_pkg::OP_STORE_FP, ricd_pkg::OP_MADD,
    ricd_pkg::OP_MSUB, ricd_pkg::OP_NMSUB, ricd_pkg::OP_NMADD, ricd_pkg::OP_FP,
    ricd_pkg::OP_VECTOR, ricd_pkg::OP_AMO};

  // Register settings of the random phases, phase 0 in the lowest five bits.
  localparam int NUM_PHASES = 8;
  localparam logic [NUM_PHASES*5-1:0] PHASE_CFG = {
    {ricd_pkg::XLEN_64, 1'b1, 1'b1, 1'b0},
    {ricd_pkg::XLEN_32, 1'b1, 1'b1, 1'b1},
    {XLEN_128,          1'b1, 1'b0, 1'b1},
    {ricd_pkg::XLEN_64, 1'b0, 1'b0, 1'b1},
    {XLEN_RESERVED,     1'b0, 1'b1, 1'b1},
    {XLEN_128,          1'b1, 1'b1, 1'b0},
    {ricd_pkg::XLEN_32, 1'b0, 1'b0, 1'b0},
    {ricd_pkg::XLEN_64, 1'b1, 1'b1, 1'b1}};

  localparam int PHASE_WORDS  = 175;
  localparam int SETTLE       = 4;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [31:0]      word;
    ricd_pkg::class_t cls;
  } decoded_t;

  // Scoreboard: decodes each accepted word and checks the classes in order.
  class class_scoreboard;
    ricd_pkg::cfg_t           cfg;
    decoded_t                 decoded_q[$];
    int                       errors;
    int                       checked;
    bit [ricd_pkg::CL_LAST:0] seen;

    function new();
      cfg = {ricd_pkg::XLEN_32, 1'b1, 1'b0, 1'b1};
      errors = 0;
      checked = 0;
      seen = '0;
    endfunction

    function ricd_pkg::class_t pick(logic [55:0] map, logic [2:0] idx);
      return map[idx*7 +: 7];
    endfunction

    // Sixteen-bit encodings; only the low halfword is looked at.
    function ricd_pkg::class_t decode_short(logic [15:0] h);
      ricd_pkg::class_t cls;
      logic [4:0]       rd;
      logic [4:0]       rs2;
      rd = h[11:7];
      rs2 = h[6:2];
      cls = ricd_pkg::CL_C_FUNC;
      if (h[1:0] == ricd_pkg::CQ_1) begin
        case (h[15:13])
          CF3_ADDI: cls = (rd != 5'd0) ? ricd_pkg::CL_C_ADDI : ricd_pkg::CL_C_FUNC;
          CF3_LI:   cls = (rd != 5'd0) ? ricd_pkg::CL_C_LI : ricd_pkg::CL_C_FUNC;
          CF3_JAL:  cls = (cfg.xlen_mode == ricd_pkg::XLEN_64) ? ricd_pkg::CL_C_FUNC
                                                               : ricd_pkg::CL_C_JUMP;
          CF3_J, CF3_BEQZ, CF3_BNEZ: cls = ricd_pkg::CL_C_JUMP;
          default:  cls = ricd_pkg::CL_C_FUNC;
        endcase
      end else if (h[1:0] == ricd_pkg::CQ_2 && h[15:13] == CF3_JRMV) begin
        if (rd != 5'd0 && rs2 == 5'd0) cls = ricd_pkg::CL_C_JUMP;
        else if (!h[12] && rd != 5'd0) cls = ricd_pkg::CL_C_MV;
      end
      return cls;
    endfunction

    // Full decode under the current register settings.
    function ricd_pkg::class_t decode_class(logic [31:0] w);
      logic [6:0]       op;
      logic [4:0]       rd;
      logic [4:0]       rs1;
      logic [2:0]       f3;
      logic [6:0]       f7;
      logic             wide;
      ricd_pkg::class_t cls;
      if (cfg.compressed_enable && w[1:0] != ricd_pkg::CQ_FULL) return decode_short(w[15:0]);
      op = w[6:0];
      rd = w[11:7];
      f3 = w[14:12];
      rs1 = w[19:15];
      f7 = w[31:25];
      wide = (cfg.xlen_mode != ricd_pkg::XLEN_32);
      case (op)
        ricd_pkg::OP_LOAD: begin
          if (rd == 5'd0) return ricd_pkg::CL_NOP;
          cls = pick(LOAD_MAP, f3);
          if (f3 == F3_DOUBLE && !wide) cls = ricd_pkg::CL_INVALID;
          return cls;
        end
        ricd_pkg::OP_STORE: begin
          cls = pick(STORE_MAP, f3);
          if (f3 == F3_DOUBLE && !wide) cls = ricd_pkg::CL_INVALID;
          return cls;
        end
        ricd_pkg::OP_BRANCH: return pick(BRANCH_MAP, f3);
        ricd_pkg::OP_LUI:    return (rd == 5'd0) ? ricd_pkg::CL_NOP : ricd_pkg::CL_LUI;
        ricd_pkg::OP_AUIPC:  return (rd == 5'd0) ? ricd_pkg::CL_NOP : ricd_pkg::CL_AUIPC;
        ricd_pkg::OP_JAL:    return ricd_pkg::CL_JAL;
        ricd_pkg::OP_JALR:   return ricd_pkg::CL_JALR;
        ricd_pkg::OP_IMM: begin
          if (rd == 5'd0) return ricd_pkg::CL_NOP;
          if (f3 == F3_ADD_SUB && rs1 == 5'd0) return ricd_pkg::CL_LI;
          if (f3 == F3_SR && w[30]) return ricd_pkg::CL_SRAI;
          return pick(IMM_MAP, f3);
        end
        ricd_pkg::OP_REG: begin
          if (rd == 5'd0) return ricd_pkg::CL_NOP;
          case (f7)
            ricd_pkg::F7_BASE:   return pick(BASE_MAP, f3);
            ricd_pkg::F7_MULDIV: return pick(MULDIV_MAP, f3);
            ricd_pkg::F7_SHADD: begin
              if (f3 == F3_SH1) return ricd_pkg::CL_SH1ADD;
              if (f3 == F3_SH2) return ricd_pkg::CL_SH2ADD;
              if (f3 == F3_SH3) return ricd_pkg::CL_SH3ADD;
              return ricd_pkg::CL_INVALID;
            end
            ricd_pkg::F7_ALT: begin
              if (f3 == F3_ADD_SUB) return ricd_pkg::CL_SUB;
              if (f3 == F3_SR) return ricd_pkg::CL_SRA;
              return ricd_pkg::CL_INVALID;
            end
            default: return ricd_pkg::CL_INVALID;
          endcase
        end
        ricd_pkg::OP_REG_32, ricd_pkg::OP_IMM_32, ricd_pkg::OP_MSUB, ricd_pkg::OP_NMSUB,
        ricd_pkg::OP_NMADD: return ricd_pkg::CL_FUNC;
        ricd_pkg::OP_SYSTEM: begin
          return (f3 == F3_PRIV && w[31:20] == 12'd0) ? ricd_pkg::CL_SYSCALL
                                                       : ricd_pkg::CL_SYSTEM;
        end
        ricd_pkg::OP_FENCE:  return ricd_pkg::CL_NOP;
        ricd_pkg::OP_LOAD_FP: begin
          if (f3 == F3_WORD) return ricd_pkg::CL_FLW;
          if (f3 == F3_DOUBLE) return ricd_pkg::CL_FLD;
          if (f3 == F3_VEC && cfg.vector_enable) return ricd_pkg::CL_VLE32;
          return ricd_pkg::CL_INVALID;
        end
        ricd_pkg::OP_STORE_FP: begin
          if (f3 == F3_WORD) return ricd_pkg::CL_FSW;
          if (f3 == F3_DOUBLE) return ricd_pkg::CL_FSD;
          if (f3 == F3_VEC && cfg.vector_enable) return ricd_pkg::CL_VSE32;
          return ricd_pkg::CL_INVALID;
        end
        ricd_pkg::OP_MADD: return ricd_pkg::CL_FMADD;
        ricd_pkg::OP_FP: begin
          return (w[31:29] == 3'd0) ? pick(FP_MAP, {1'b0, w[28:27]}) : ricd_pkg::CL_FUNC;
        end
        ricd_pkg::OP_VECTOR: return cfg.vector_enable ? ricd_pkg::CL_FUNC
                                                      : ricd_pkg::CL_INVALID;
        ricd_pkg::OP_AMO:    return cfg.atomics_enable ? ricd_pkg::CL_FUNC
                                                       : ricd_pkg::CL_INVALID;
        default:             return ricd_pkg::CL_INVALID;
      endcase
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note_word(logic [31:0] w);
      decoded_t d;
      d.word = w;
      d.cls = decode_class(w);
      decoded_q.push_back(d);
    endfunction

    task check_class(ricd_pkg::class_t got);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("class %0d arrived with no instruction outstanding", got));
      end else begin
        want = decoded_q.pop_front();
        checked++;
        if (got <= ricd_pkg::CL_LAST) seen[got] = 1'b1;
        if (got !== want.cls)
          report($sformatf("word %08h gave class %0d, expected %0d", want.word, got, want.cls));
      end
    endtask

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [1:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] instr_word;
  logic        out_valid;
  logic        out_ready;
  logic [6:0]  handler_class;

  class_scoreboard sb;
  bit              allow_idle;
  bit              sender_busy_window;
  int              cycles;

  riscv_instruction_class_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .instr_word    (instr_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .handler_class (handler_class)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Cycle count and run limit.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Both transfers are observed at the rising edge; the input side is noted first.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_word(instr_word);
    if (!rst && out_valid && out_ready) sb.check_class(handler_class);
  end

  // Result side: ready stalls in bursts, with long calm stretches in between.
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      if (allow_idle && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 12)) @(negedge clk);
    end
  end

  function automatic logic [31:0] enc(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                      logic [4:0] rs1, logic [4:0] rs2, logic [6:0] f7);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  // Mostly well-formed instructions with random operands, some compressed, some noise.
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    int          sel;
    w = $urandom();
    sel = $urandom_range(0, 99);
    if (sel < 15) return w;
    if (sel < 35) begin
      w[1:0] = 2'($urandom_range(ricd_pkg::CQ_0, ricd_pkg::CQ_2));
      if ($urandom_range(0, 3) == 0) w[11:7] = 5'd0;
      if ($urandom_range(0, 3) == 0) w[6:2] = 5'd0;
      return w;
    end
    w[6:0] = OPCODES[$urandom_range(0, NUM_OPCODES - 1)*7 +: 7];
    if ($urandom_range(0, 4) == 0) w[11:7] = 5'd0;
    if ($urandom_range(0, 4) == 0) w[19:15] = 5'd0;
    case ($urandom_range(0, 4))
      0: w[31:25] = ricd_pkg::F7_BASE;
      1: w[31:25] = ricd_pkg::F7_MULDIV;
      2: w[31:25] = ricd_pkg::F7_SHADD;
      3: w[31:25] = ricd_pkg::F7_ALT;
      default: ;
    endcase
    if (w[6:0] == ricd_pkg::OP_SYSTEM && $urandom_range(0, 1) == 0) begin
      w[31:20] = 12'd0;
      if ($urandom_range(0, 1) == 0) w[14:12] = F3_PRIV;
    end
    if (w[6:0] == ricd_pkg::OP_FP && $urandom_range(0, 1) == 0) w[31:29] = 3'd0;
    return w;
  endfunction

  // Offer one word from a falling edge and hold it until the transfer; ends at a falling edge.
  task automatic send_word(logic [31:0] w);
    in_valid = 1'b1;
    instr_word = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (allow_idle && sender_busy_window && $urandom_range(0, 2) == 0) begin
      in_valid = 1'b0;
      instr_word = $urandom();
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // Hold off until every class has come back and the pipeline has emptied.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic apply_config(ricd_pkg::cfg_t c);
    sb.cfg = c;
    write_reg(ricd_pkg::REG_XLEN_MODE, c.xlen_mode);
    write_reg(ricd_pkg::REG_COMPRESSED, {1'b0, c.compressed_enable});
    write_reg(ricd_pkg::REG_VECTOR, {1'b0, c.vector_enable});
    write_reg(ricd_pkg::REG_ATOMICS, {1'b0, c.atomics_enable});
    @(negedge clk);
  endtask

  // Directed words under the reset settings: extremes, several compressed forms and corner cases.
  task automatic run_directed();
    send_word(32'h0000_0000);                                     // quadrant 0
    send_word(32'hFFFF_FFFF);                                     // unknown opcode
    send_word(32'h0000_0085);                                     // c.addi x1
    send_word(32'h0000_0001);                                     // c.addi to x0
    send_word(32'hFFFF_4085);                                     // c.li x1, upper half set
    send_word(32'h0000_2001);                                     // c.jal at 32 bits
    send_word(32'h0000_A001);                                     // c.j
    send_word(32'h0000_8082);                                     // c.jr
    send_word(32'h0000_8086);                                     // c.mv
    send_word(32'h0000_9086);                                     // c.add
    send_word(enc(ricd_pkg::OP_LOAD, 5'd1, F3_DOUBLE, 5'd2, 5'd0, ricd_pkg::F7_BASE));
    send_word(enc(ricd_pkg::OP_LOAD, 5'd0, F3_WORD, 5'd2, 5'd0, ricd_pkg::F7_BASE));
    send_word(enc(ricd_pkg::OP_STORE, 5'd1, F3_DOUBLE, 5'd2, 5'd3, ricd_pkg::F7_BASE));
    send_word(enc(ricd_pkg::OP_REG, 5'd1, F3_ADD_SUB, 5'd2, 5'd3, ricd_pkg::F7_ALT));
    send_word(enc(ricd_pkg::OP_REG, 5'd1, F3_SR, 5'd2, 5'd3, ricd_pkg::F7_ALT));
    send_word(enc(ricd_pkg::OP_REG, 5'd31, F3_SH3, 5'd31, 5'd31, ricd_pkg::F7_SHADD));
    // li form and srai
    send_word(enc(ricd_pkg::OP_IMM, 5'd1, F3_ADD_SUB, 5'd0, 5'd7, ricd_pkg::F7_BASE));
    send_word(enc(ricd_pkg::OP_IMM, 5'd1, F3_SR, 5'd1, 5'd3, ricd_pkg::F7_ALT));
    // ecall and ebreak
    send_word(enc(ricd_pkg::OP_SYSTEM, 5'd0, F3_PRIV, 5'd0, 5'd0, ricd_pkg::F7_BASE));
    send_word(enc(ricd_pkg::OP_SYSTEM, 5'd0, F3_PRIV, 5'd0, 5'd1, ricd_pkg::F7_BASE));
    send_word(enc(ricd_pkg::OP_FP, 5'd1, F3_ADD_SUB, 5'd1, 5'd2, 7'h0C));     // fdiv
    // Vector load while vector decode is off.
    send_word(enc(ricd_pkg::OP_LOAD_FP, 5'd1, F3_VEC, 5'd2, 5'd0, ricd_pkg::F7_BASE));
    send_word(enc(ricd_pkg::OP_VECTOR, 5'd1, F3_ADD_SUB, 5'd2, 5'd3, ricd_pkg::F7_BASE));
    send_word(enc(ricd_pkg::OP_AMO, 5'd1, F3_WORD, 5'd2, 5'd3, ricd_pkg::F7_BASE));
    send_word(enc(ricd_pkg::OP_FENCE, 5'd0, F3_ADD_SUB, 5'd0, 5'd0, ricd_pkg::F7_BASE));
  endtask

  // Main sequence: reset, directed words, then random phases under changing settings.
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = ricd_pkg::REG_XLEN_MODE;
    cfg_data = 2'd0;
    in_valid = 1'b0;
    instr_word = 32'd0;
    allow_idle = 1'b1;
    sender_busy_window = 1'b1;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    run_directed();
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == NUM_PHASES - 1) allow_idle = 1'b0;
      apply_config(PHASE_CFG[p*5 +: 5]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 40 == 0) sender_busy_window = ($urandom_range(0, 2) != 0);
        send_word(rand_word());
        sender_gap();
      end
    end
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE * 4) @(posedge clk);
    $display("tb: %0d instruction words checked over %0d register settings",
             sb.checked, NUM_PHASES + 1);
    $display("tb: %0d of %0d handler classes produced, %0d mismatches",
             $countones(sb.seen), ricd_pkg::CL_LAST + 1, sb.errors);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
